// ----- rtl/lttw_pkg.sv -----
// Shared types and constants for the low-throughput watchdog.
`timescale 1ns / 1ps
`default_nettype none

package lttw_pkg;

    // Width of the rates; the rate sum is one bit wider
    localparam int RATE_BITS = 64;

    // Nanoseconds per second, the fixed multiplier of every rate
    localparam int SCALE_BITS = 30;
    localparam logic [SCALE_BITS-1:0] NS_PER_SEC = 30'd1000000000;

    // Failure streak counter and its ceiling
    localparam int STREAK_BITS = 17;
    localparam logic [STREAK_BITS-1:0] STREAK_MAX = 17'd65536;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int ALLOWED_BITS = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIN_RATE         = 2'd0,
        REG_ALLOWED_FAILURES = 2'd1
    } cfg_reg_t;

    // Status reported with every item
    typedef enum logic [2:0] {
        VERDICT_DISABLED = 3'd0,
        VERDICT_IDLE     = 3'd1,
        VERDICT_OVERFLOW = 3'd2,
        VERDICT_OK       = 3'd3,
        VERDICT_LOW      = 3'd4,
        VERDICT_SHUTDOWN = 3'd5
    } verdict_t;

endpackage

`default_nettype wire

// ----- rtl/lttw_rate.sv -----
// Bit-serial rate unit: shift-add multiply by 1e9, then restoring division by the wait time.
`timescale 1ns / 1ps
`default_nettype none

module lttw_rate #(
    parameter int COUNT_BITS = 48
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [COUNT_BITS-1:0]          bytes,
    input  wire logic [COUNT_BITS-1:0]          ns,
    output logic                                done,
    output logic [lttw_pkg::RATE_BITS-1:0]      rate
);

    localparam int PW   = COUNT_BITS + lttw_pkg::SCALE_BITS;
    localparam int CNTW = $clog2(PW);
    localparam int SB   = lttw_pkg::SCALE_BITS;
    localparam int RB   = lttw_pkg::RATE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]  bytes_reg, bytes_next;
    logic [COUNT_BITS-1:0]  ns_reg, ns_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [RB-1:0]          q_reg, q_next;
    logic                   ovf_reg, ovf_next;

    logic [COUNT_BITS:0]    mul_sum;
    logic [COUNT_BITS:0]    div_shift;
    logic [COUNT_BITS+1:0]  div_diff;
    logic                   div_ge;

    // One multiply step: add the multiplicand when the low bit is set, shift right
    assign mul_sum = {1'b0, prod_reg[PW-1:SB]}
                   + (prod_reg[0] ? {1'b0, bytes_reg} : {(COUNT_BITS+1){1'b0}});

    // One division step: bring in the next product bit, trial-subtract the divisor
    assign div_shift = {rem_reg, prod_reg[PW-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, ns_reg};
    assign div_ge    = !div_diff[COUNT_BITS+1];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        ns_next    = ns_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        if (start)
        begin
            // Load operands; a zero wait time gives a zero rate at once
            bytes_next = bytes;
            ns_next    = ns;
            prod_next  = {{COUNT_BITS{1'b0}}, lttw_pkg::NS_PER_SEC};
            cnt_next   = '0;
            q_next     = '0;
            ovf_next   = 1'b0;
            rem_next   = '0;
            state_next = (ns == '0) ? ST_DONE : ST_MUL;
        end
        else
        begin
            unique case (state_reg)
                ST_MUL:
                begin
                    prod_next = {mul_sum, prod_reg[SB-1:1]};
                    if (cnt_reg == CNTW'(SB - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_DIV:
                begin
                    prod_next = {prod_reg[PW-2:0], 1'b0};
                    rem_next  = div_ge ? div_diff[COUNT_BITS-1:0]
                                       : div_shift[COUNT_BITS-1:0];
                    q_next    = {q_reg[RB-2:0], div_ge};
                    // Quotient bits beyond 64 mean saturation
                    ovf_next  = ovf_reg | q_reg[RB-1];
                    if (cnt_reg == CNTW'(PW - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_IDLE, ST_DONE:
                begin
                    state_next = state_reg;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Advance the datapath shift registers
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        ns_reg    <= ns_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        ovf_reg   <= ovf_next;
    end

    assign done = (state_reg == ST_DONE);
    assign rate = ovf_reg ? {RB{1'b1}} : q_reg;

endmodule

`default_nettype wire

// ----- rtl/low_throughput_watchdog.sv -----
// Top level of the low-throughput watchdog: control sequencer, streak counter, output register.
//
// Usage: one input transaction per sampling interval (read/written bytes and read/write
// wait times in ns), accepted when in_valid is high and in_stall is low. One result
// transaction (total_rate, failure_count, verdict) follows per input, offered with
// out_valid and taken when out_stall is low. Configuration writes (cfg_index, cfg_data)
// complete when cfg_valid and cfg_ready are high; index 0 is min_rate, index 1 is
// allowed_failures, other indexes are dropped. cfg_ready is always high.
// Flow: a disabled or idle interval goes from acceptance straight to the output stage. A
// measured interval runs both directions in parallel through bit-serial rate units:
// multiply steps, then division steps, then done, sum, compare and output stages, and
// only then does out_valid rise. A new measured item is not taken before the previous
// result has left the sequencer.
// One item is in flight at a time; in_stall is high from acceptance until the result is
// moved into the output register, so the next item enters while a result still waits.
// A stalled result holds in the output register; the sequencer waits at its final stage.
// Reset clears the configuration (monitor disabled), the streak and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module low_throughput_watchdog #(
    parameter int COUNT_BITS = 48
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [COUNT_BITS-1:0]                read_bytes,
    input  wire logic [COUNT_BITS-1:0]                written_bytes,
    input  wire logic [COUNT_BITS-1:0]                read_wait_ns,
    input  wire logic [COUNT_BITS-1:0]                write_wait_ns,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [lttw_pkg::RATE_BITS-1:0]            total_rate,
    output logic [lttw_pkg::STREAK_BITS-1:0]          failure_count,
    output logic [2:0]                                verdict,
    // configuration channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lttw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [lttw_pkg::RATE_BITS-1:0]       cfg_data
);

    localparam int RB = lttw_pkg::RATE_BITS;
    localparam int SW = lttw_pkg::STREAK_BITS;
    localparam int AB = lttw_pkg::ALLOWED_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_SUM,
        ST_CMP,
        ST_PUT
    } state_t;

    state_t              state_reg, state_next;
    logic [RB-1:0]       min_rate_reg, min_rate_next;
    logic [AB-1:0]       allowed_reg, allowed_next;
    logic [SW-1:0]       streak_reg, streak_next;
    logic                out_valid_reg, out_valid_next;

    logic [RB:0]         sum_reg, sum_next;
    logic [RB-1:0]       res_rate_reg, res_rate_next;
    lttw_pkg::verdict_t  res_verdict_reg, res_verdict_next;
    logic [RB-1:0]       total_rate_reg, total_rate_next;
    logic [SW-1:0]       count_reg, count_next;
    lttw_pkg::verdict_t  verdict_reg, verdict_next;

    logic                in_acc;
    logic                disabled;
    logic                quiet;
    logic                lane_start;
    logic                rd_done, wr_done;
    logic [RB-1:0]       rd_rate, wr_rate;
    logic [SW-1:0]       streak_inc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign disabled  = (min_rate_reg == '0) || (allowed_reg == '0);
    assign quiet     = (read_wait_ns == '0) && (write_wait_ns == '0);
    assign lane_start = in_acc && !disabled && !quiet;
    assign cfg_ready = 1'b1;

    assign streak_inc = (streak_reg == lttw_pkg::STREAK_MAX) ? lttw_pkg::STREAK_MAX
                                                             : streak_reg + 1'b1;

    // Read and write direction rate units
    lttw_rate #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rd_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .bytes (read_bytes),
        .ns    (read_wait_ns),
        .done  (rd_done),
        .rate  (rd_rate)
    );

    lttw_rate #(
        .COUNT_BITS (COUNT_BITS)
    ) u_wr_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .bytes (written_bytes),
        .ns    (write_wait_ns),
        .done  (wr_done),
        .rate  (wr_rate)
    );

    always_comb
    begin
        state_next       = state_reg;
        min_rate_next    = min_rate_reg;
        allowed_next     = allowed_reg;
        streak_next      = streak_reg;
        out_valid_next   = out_valid_reg && out_stall;
        sum_next         = sum_reg;
        res_rate_next    = res_rate_reg;
        res_verdict_next = res_verdict_reg;
        total_rate_next  = total_rate_reg;
        count_next       = count_reg;
        verdict_next     = verdict_reg;

        // Take configuration writes; unknown indexes are dropped
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lttw_pkg::REG_MIN_RATE:         min_rate_next = cfg_data;
                lttw_pkg::REG_ALLOWED_FAILURES: allowed_next  = cfg_data[AB-1:0];
                default:                        min_rate_next = min_rate_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_rate_next = '0;
                    if (disabled)
                    begin
                        res_verdict_next = lttw_pkg::VERDICT_DISABLED;
                        state_next       = ST_PUT;
                    end
                    else if (quiet)
                    begin
                        streak_next      = '0;
                        res_verdict_next = lttw_pkg::VERDICT_IDLE;
                        state_next       = ST_PUT;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (rd_done && wr_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next   = {1'b0, rd_rate} + {1'b0, wr_rate};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // Classify the interval and update the streak
                if (sum_reg[RB])
                begin
                    streak_next      = '0;
                    res_rate_next    = '0;
                    res_verdict_next = lttw_pkg::VERDICT_OVERFLOW;
                end
                else if (sum_reg[RB-1:0] >= min_rate_reg)
                begin
                    streak_next      = '0;
                    res_rate_next    = sum_reg[RB-1:0];
                    res_verdict_next = lttw_pkg::VERDICT_OK;
                end
                else
                begin
                    streak_next      = streak_inc;
                    res_rate_next    = sum_reg[RB-1:0];
                    res_verdict_next = (streak_inc > {1'b0, allowed_reg})
                                     ? lttw_pkg::VERDICT_SHUTDOWN
                                     : lttw_pkg::VERDICT_LOW;
                end
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                // Move the result into the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    total_rate_next = res_rate_reg;
                    count_next      = streak_reg;
                    verdict_next    = res_verdict_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, configuration, streak and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_rate_reg  <= '0;
            allowed_reg   <= '0;
            streak_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_rate_reg  <= min_rate_next;
            allowed_reg   <= allowed_next;
            streak_reg    <= streak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result and output payload
    always_ff @(posedge clk)
    begin
        sum_reg         <= sum_next;
        res_rate_reg    <= res_rate_next;
        res_verdict_reg <= res_verdict_next;
        total_rate_reg  <= total_rate_next;
        count_reg       <= count_next;
        verdict_reg     <= verdict_next;
    end

    assign out_valid     = out_valid_reg;
    assign total_rate    = total_rate_reg;
    assign failure_count = count_reg;
    assign verdict       = verdict_reg;

endmodule

`default_nettype wire

// ----- rtl/lttw_checker.sv -----
// Port-level assertions for the low-throughput watchdog, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lttw_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic [lttw_pkg::RATE_BITS-1:0]       total_rate,
    input wire logic [lttw_pkg::STREAK_BITS-1:0]     failure_count,
    input wire logic [2:0]                           verdict
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(total_rate) && $stable(failure_count)
                                   && $stable(verdict))
        else $error("result changed while stalled");

    // Idle and overflow intervals clear the streak and report no rate
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == lttw_pkg::VERDICT_IDLE
                      || verdict == lttw_pkg::VERDICT_OVERFLOW)
        |-> total_rate == '0 && failure_count == '0)
        else $error("idle or overflow result with nonzero rate or count");

    // A healthy interval clears the streak; a low one leaves it nonzero
    a_ok_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == lttw_pkg::VERDICT_OK |-> failure_count == '0)
        else $error("ok result with nonzero failure count");

    a_low_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == lttw_pkg::VERDICT_LOW
                      || verdict == lttw_pkg::VERDICT_SHUTDOWN)
        |-> failure_count != '0 && failure_count <= lttw_pkg::STREAK_MAX)
        else $error("low result with bad failure count");

endmodule

bind low_throughput_watchdog lttw_checker u_lttw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .total_rate    (total_rate),
    .failure_count (failure_count),
    .verdict       (verdict)
);

`default_nettype wire

// ----- test/lttw_checker.sv -----
`timescale 1ns / 1ps
// Status checker for the low-throughput watchdog: predicts and compares every status transaction.

module lttw_status_checker #(
    parameter int COUNT_BITS = 48
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_stall,
    input  wire logic [COUNT_BITS-1:0]                read_bytes,
    input  wire logic [COUNT_BITS-1:0]                written_bytes,
    input  wire logic [COUNT_BITS-1:0]                read_wait_ns,
    input  wire logic [COUNT_BITS-1:0]                write_wait_ns,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_stall,
    input  wire logic [lttw_pkg::RATE_BITS-1:0]       total_rate,
    input  wire logic [lttw_pkg::STREAK_BITS-1:0]     failure_count,
    input  wire logic [2:0]                           verdict,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic [lttw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [lttw_pkg::RATE_BITS-1:0]       cfg_data,
    output int                                        failures,
    output int                                        pending
);

    localparam int REPORT_LIMIT = 10;
    localparam int RATE_BITS    = lttw_pkg::RATE_BITS;
    localparam int STREAK_BITS  = lttw_pkg::STREAK_BITS;
    localparam int ALLOWED_BITS = lttw_pkg::ALLOWED_BITS;

    typedef struct {
        logic [RATE_BITS-1:0]   rate;
        logic [STREAK_BITS-1:0] count;
        lttw_pkg::verdict_t     status;
    } interval_status_t;

    // Shadow copy of the configuration and of the low streak
    logic [RATE_BITS-1:0]    min_rate;
    logic [ALLOWED_BITS-1:0] allowed_failures;
    logic [STREAK_BITS-1:0]  low_streak;

    interval_status_t expected_status[$];
    interval_status_t oldest;

    // floor(bytes * 1e9 / ns), saturated to the rate width; ns is nonzero
    function automatic logic [RATE_BITS-1:0] direction_rate(
        input logic [COUNT_BITS-1:0] bytes,
        input logic [COUNT_BITS-1:0] ns
    );
        logic [127:0] scaled;
        logic [127:0] quotient;
        scaled   = 128'(bytes) * 128'(lttw_pkg::NS_PER_SEC);
        quotient = scaled / 128'(ns);
        if (quotient[127:RATE_BITS] != '0)
            return '1;
        return quotient[RATE_BITS-1:0];
    endfunction

    // Work out the status of one interval and advance the streak
    function automatic interval_status_t predict_status(
        input logic [COUNT_BITS-1:0] rbytes,
        input logic [COUNT_BITS-1:0] wbytes,
        input logic [COUNT_BITS-1:0] rns,
        input logic [COUNT_BITS-1:0] wns
    );
        interval_status_t result;
        logic [STREAK_BITS-1:0] prev;
        logic [RATE_BITS-1:0]   read_rate;
        logic [RATE_BITS-1:0]   write_rate;
        logic [RATE_BITS:0]     rate_sum;
        result.rate   = '0;
        result.count  = '0;
        result.status = lttw_pkg::VERDICT_DISABLED;
        if (min_rate == '0 || allowed_failures == '0) begin
            result.count = low_streak;
            return result;
        end
        prev       = low_streak;
        low_streak = '0;
        if (rns == '0 && wns == '0) begin
            result.status = lttw_pkg::VERDICT_IDLE;
            return result;
        end
        read_rate  = (rns != '0) ? direction_rate(rbytes, rns) : '0;
        write_rate = (wns != '0) ? direction_rate(wbytes, wns) : '0;
        rate_sum   = {1'b0, read_rate} + {1'b0, write_rate};
        if (rate_sum[RATE_BITS]) begin
            result.status = lttw_pkg::VERDICT_OVERFLOW;
            return result;
        end
        result.rate = rate_sum[RATE_BITS-1:0];
        if (result.rate >= min_rate) begin
            result.status = lttw_pkg::VERDICT_OK;
        end
        else begin
            low_streak    = (prev >= lttw_pkg::STREAK_MAX) ? lttw_pkg::STREAK_MAX
                                                           : prev + 1'b1;
            result.status = ({1'b0, low_streak} > 18'(allowed_failures)) ?
                            lttw_pkg::VERDICT_SHUTDOWN : lttw_pkg::VERDICT_LOW;
        end
        result.count = low_streak;
        return result;
    endfunction

    // Follow all three channels at each clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate         = '0;
            allowed_failures = '0;
            low_streak       = '0;
            expected_status.delete();
            failures         = 0;
            pending          = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (lttw_pkg::cfg_reg_t'(cfg_index))
                    lttw_pkg::REG_MIN_RATE:
                        min_rate = cfg_data;
                    lttw_pkg::REG_ALLOWED_FAILURES:
                        allowed_failures = cfg_data[ALLOWED_BITS-1:0];
                    default: ;
                endcase
            end

            // Predict on every accepted interval
            if (in_valid && !in_stall)
                expected_status.push_back(predict_status(read_bytes, written_bytes,
                                                         read_wait_ns, write_wait_ns));

            // Compare every accepted status against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    if (failures < REPORT_LIMIT)
                        $display("unexpected status: rate %0d count %0d verdict %0d",
                                 total_rate, failure_count, verdict);
                    failures++;
                end
                else
                begin
                    oldest = expected_status.pop_front();
                    if (total_rate !== oldest.rate || failure_count !== oldest.count ||
                        verdict !== oldest.status)
                    begin
                        if (failures < REPORT_LIMIT)
                            $display({"status mismatch: rate exp %0d got %0d, ",
                                      "count exp %0d got %0d, verdict exp %0d (%s) got %0d"},
                                     oldest.rate, total_rate, oldest.count, failure_count,
                                     oldest.status, oldest.status.name(), verdict);
                        failures++;
                    end
                end
            end
            pending = expected_status.size();
        end
    end

endmodule

// ----- test/low_throughput_watchdog_test.sv -----
`timescale 1ns / 1ps
// Top of the watchdog testbench: clock, reset, stimulus, back-pressure and the final verdict.

module low_throughput_watchdog_test;

    localparam int COUNT_BITS    = 48;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 104;
    localparam int CALM_ITEMS    = 60;

    localparam int RATE_BITS      = lttw_pkg::RATE_BITS;
    localparam int STREAK_BITS    = lttw_pkg::STREAK_BITS;
    localparam int CFG_INDEX_BITS = lttw_pkg::CFG_INDEX_BITS;
    localparam int ALLOWED_BITS   = lttw_pkg::ALLOWED_BITS;

    // Indexes past the register list; writes to them are dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP  = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0] ONE_SECOND = 48'd1000000000;
    localparam logic [COUNT_BITS-1:0] ONE_MSEC   = 48'd1000000;
    localparam logic [RATE_BITS-1:0]  RATE_MAX   = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [COUNT_BITS-1:0]         read_bytes = '0;
    logic [COUNT_BITS-1:0]         written_bytes = '0;
    logic [COUNT_BITS-1:0]         read_wait_ns = '0;
    logic [COUNT_BITS-1:0]         write_wait_ns = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [RATE_BITS-1:0]          total_rate;
    logic [STREAK_BITS-1:0]        failure_count;
    logic [2:0]                    verdict;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
    logic [RATE_BITS-1:0]          cfg_data = '0;

    int  failures;
    int  pending;
    int  cycles = 0;
    bit  calm = 1'b0;

    low_throughput_watchdog #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .read_bytes(read_bytes),
        .written_bytes(written_bytes),
        .read_wait_ns(read_wait_ns),
        .write_wait_ns(write_wait_ns),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .total_rate(total_rate),
        .failure_count(failure_count),
        .verdict(verdict),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lttw_status_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) status_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .read_bytes(read_bytes),
        .written_bytes(written_bytes),
        .read_wait_ns(read_wait_ns),
        .write_wait_ns(write_wait_ns),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .total_rate(total_rate),
        .failure_count(failure_count),
        .verdict(verdict),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .failures(failures),
        .pending(pending)
    );

    // Free-running clock
    always #(HALF_PERIOD) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Apply back-pressure on the status channel in random bursts
    initial
    begin
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(200, 400)) @(posedge clk);
            else
                repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Random count of the given bit width
    function automatic logic [COUNT_BITS-1:0] random_count(input int width);
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        if (width <= 0)
            return '0;
        return COUNT_BITS'(raw & ((64'd1 << width) - 64'd1));
    endfunction

    // Write one register; the channel is idle again when the task returns
    task automatic write_reg(
        input logic [CFG_INDEX_BITS-1:0] index,
        input logic [RATE_BITS-1:0]      data
    );
        logic granted;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        granted = 1'b0;
        while (!granted)
        begin
            @(negedge clk);
            granted = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one interval, hold it until taken, then maybe idle for a burst
    task automatic send_interval(
        input logic [COUNT_BITS-1:0] rbytes,
        input logic [COUNT_BITS-1:0] wbytes,
        input logic [COUNT_BITS-1:0] rns,
        input logic [COUNT_BITS-1:0] wns,
        input bit                    drop_after
    );
        logic taken;
        bit   gap;
        in_valid      <= 1'b1;
        read_bytes    <= rbytes;
        written_bytes <= wbytes;
        read_wait_ns  <= rns;
        write_wait_ns <= wns;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        gap = !calm && ($urandom_range(0, 3) == 0);
        if (drop_after || gap)
            in_valid <= 1'b0;
        if (gap)
            repeat ($urandom_range(1, 11)) @(posedge clk);
    endtask

    // Wait until every predicted status has been taken
    task automatic wait_for_results();
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [COUNT_BITS-1:0] rb, wb, rn, wn, swap_bytes, swap_ns;
        logic [RATE_BITS-1:0]  min_rate_data, allowed_data, phase_min_rate;
        logic [127:0]          break_even;
        int                    kind;
        int                    pick;

        // Hold reset, then release on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Monitor disabled out of reset
        send_interval(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
        send_interval('0, '0, '0, '0, 1'b1);
        wait_for_results();

        // Enable; upper bits of the allowed count are dropped, spare indexes ignored
        write_reg(lttw_pkg::REG_MIN_RATE, 64'd1000);
        write_reg(lttw_pkg::REG_ALLOWED_FAILURES, 64'hFFFF_FFFF_FFFF_0002);
        write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
        write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
        send_interval(COUNT_MAX, 48'd5, '0, '0, 1'b0);             // both waits zero
        send_interval(COUNT_MAX, 48'd1, 48'd1, 48'd1, 1'b0);       // rate sum overflows
        send_interval(COUNT_MAX, COUNT_MAX, 48'd1, '0, 1'b0);      // one saturated rate
        send_interval(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
        send_interval('0, '0, COUNT_MAX, COUNT_MAX, 1'b0);         // zero rate, streak grows
        send_interval(48'd1, '0, COUNT_MAX, '0, 1'b0);
        send_interval('0, '0, 48'd1, 48'd1, 1'b0);                 // streak passes the limit
        send_interval('0, 48'd7, COUNT_MAX, '0, 1'b0);
        send_interval(48'd1, '0, ONE_MSEC, '0, 1'b0);              // exactly at the minimum
        send_interval(48'd999, '0, ONE_SECOND, '0, 1'b0);          // one below the minimum
        send_interval('0, 48'd5, '0, ONE_SECOND, 1'b1);            // write side only
        wait_for_results();

        // Disable through each register in turn; the streak must hold
        write_reg(lttw_pkg::REG_MIN_RATE, '0);
        send_interval(COUNT_MAX, COUNT_MAX, 48'd1, 48'd1, 1'b1);
        wait_for_results();
        write_reg(lttw_pkg::REG_MIN_RATE, RATE_MAX);
        write_reg(lttw_pkg::REG_ALLOWED_FAILURES, 64'h0000_0000_0001_0000);
        send_interval(48'd1, 48'd1, 48'd1, 48'd1, 1'b1);
        wait_for_results();

        // Largest settings
        write_reg(lttw_pkg::REG_ALLOWED_FAILURES, 64'h0000_0000_0000_FFFF);
        send_interval(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
        send_interval(COUNT_MAX, '0, 48'd1, '0, 1'b1);
        wait_for_results();

        // Smallest settings
        write_reg(lttw_pkg::REG_MIN_RATE, 64'd1);
        write_reg(lttw_pkg::REG_ALLOWED_FAILURES, 64'd1);
        send_interval('0, '0, 48'd5, 48'd5, 1'b0);
        send_interval('0, '0, 48'd5, 48'd5, 1'b0);
        send_interval(48'd1, '0, ONE_SECOND, '0, 1'b1);
        wait_for_results();

        // Random phases, each under its own configuration
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                min_rate_data = RATE_MAX;
                allowed_data  = 64'd1;
            end
            else if (phase == 1)
            begin
                min_rate_data = 64'd1;
                allowed_data  = {$urandom(), 16'($urandom_range(0, 65535)), 16'hFFFF};
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    min_rate_data = '0;
                else if (pick == 1)
                    min_rate_data = RATE_MAX;
                else
                    min_rate_data = {$urandom(), $urandom()} >> $urandom_range(0, 63);
                allowed_data = {$urandom(), $urandom()};
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    allowed_data[ALLOWED_BITS-1:0] = '0;
                else if (pick == 1)
                    allowed_data[ALLOWED_BITS-1:0] = '1;
                else if (pick > 2)
                    allowed_data[ALLOWED_BITS-1:0] = ALLOWED_BITS'($urandom_range(1, 8));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          {$urandom(), $urandom()});
            write_reg(lttw_pkg::REG_MIN_RATE, min_rate_data);
            write_reg(lttw_pkg::REG_ALLOWED_FAILURES, allowed_data);
            phase_min_rate = min_rate_data;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == RANDOM_PHASES - 1 && n >= PHASE_ITEMS - CALM_ITEMS)
                    calm <= 1'b1;
                kind = $urandom_range(0, 99);
                if (kind < 8)
                begin
                    // Nothing waiting
                    rb = random_count($urandom_range(0, COUNT_BITS));
                    wb = random_count($urandom_range(0, COUNT_BITS));
                    rn = '0;
                    wn = '0;
                end
                else if (kind < 14)
                begin
                    // Near-saturated rate plus a second rate
                    rb = COUNT_MAX - COUNT_BITS'($urandom_range(0, 255));
                    rn = COUNT_BITS'($urandom_range(1, 16));
                    wb = random_count($urandom_range(20, COUNT_BITS));
                    wn = COUNT_BITS'($urandom_range(1, 1 << 20));
                end
                else if (kind < 55)
                begin
                    // Rate right around the minimum, mostly just below it
                    rn = random_count($urandom_range(1, COUNT_BITS));
                    if (rn == '0)
                        rn = 48'd1;
                    break_even = (128'(phase_min_rate) * 128'(rn))
                               / 128'(lttw_pkg::NS_PER_SEC);
                    if ($urandom_range(0, 9) < 7)
                        break_even = (break_even > 128'd2) ?
                                     break_even - 128'($urandom_range(0, 2)) : '0;
                    else
                        break_even = break_even + 128'($urandom_range(1, 2));
                    rb = (break_even > 128'(COUNT_MAX)) ? COUNT_MAX : break_even[COUNT_BITS-1:0];
                    wb = random_count($urandom_range(0, COUNT_BITS));
                    wn = '0;
                end
                else if (kind < 75)
                begin
                    // Trickle of bytes over long waits
                    rb = COUNT_BITS'($urandom_range(0, 1023));
                    wb = COUNT_BITS'($urandom_range(0, 1023));
                    rn = COUNT_TOP | random_count(COUNT_BITS - 1);
                    wn = $urandom_range(0, 1) ? (COUNT_TOP | random_count(COUNT_BITS - 1)) : '0;
                end
                else
                begin
                    rb = random_count($urandom_range(0, COUNT_BITS));
                    wb = random_count($urandom_range(0, COUNT_BITS));
                    rn = random_count($urandom_range(0, COUNT_BITS));
                    wn = random_count($urandom_range(0, COUNT_BITS));
                end
                // Swap directions at random
                if ($urandom_range(0, 1))
                begin
                    swap_bytes = rb;
                    swap_ns    = rn;
                    rb = wb;
                    rn = wn;
                    wb = swap_bytes;
                    wn = swap_ns;
                end
                send_interval(rb, wb, rn, wn, n == PHASE_ITEMS - 1);
            end
            wait_for_results();
        end

        // Drain, then give the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- low_throughput_watchdog.f -----
rtl/lttw_pkg.sv
rtl/lttw_rate.sv
rtl/low_throughput_watchdog.sv
rtl/lttw_checker.sv
test/lttw_checker.sv
test/low_throughput_watchdog_test.sv
